[design/assert_macros.svh]
// Assertion macros shared by the PRESENT-80 unit modules.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define PRES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication form of the check above
`define PRES_ASSERT_IMP(label, pre, post, msg) \
  `PRES_ASSERT(label, (pre) |-> (post), msg)

`endif

[design/pres_pkg.sv]
// Shared types, constants and round functions of the PRESENT-80 unit.
// Used by pres_kexp, pres_round_cell and present80_block_cipher_unit.
`default_nettype none

package pres_pkg;

  localparam int unsigned NUM_ROUNDS = 31;
  localparam int unsigned ROUND_W    = 5;
  localparam int unsigned BLK_W      = 64;
  localparam int unsigned KEY_W      = 80;

  typedef enum logic {
    CMD_ENC = 1'b0,
    CMD_DEC = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KX_IDLE,
    KX_LOAD,
    KX_RUN
  } kx_state_e;

  // paddr[3] selects the register
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    cmd_e               cmd;
    logic [BLK_W-1:0]   blk;
    logic [KEY_W-1:0]   key;
  } stage_t;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  localparam logic [3:0] SBOX_INV [16] = '{
    4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
    4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
  };

  function automatic logic [BLK_W-1:0] sbox_layer(input logic [BLK_W-1:0] x);
    logic [BLK_W-1:0] r;
    r = '0;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = SBOX[x[4*n +: 4]];
    end
    return r;
  endfunction

  function automatic logic [BLK_W-1:0] sbox_inv_layer(input logic [BLK_W-1:0] x);
    logic [BLK_W-1:0] r;
    r = '0;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = SBOX_INV[x[4*n +: 4]];
    end
    return r;
  endfunction

  function automatic logic [BLK_W-1:0] perm_layer(input logic [BLK_W-1:0] x);
    logic [BLK_W-1:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      r[16*(i%4) + i/4] = x[i];
    end
    return r;
  endfunction

  function automatic logic [BLK_W-1:0] perm_inv_layer(input logic [BLK_W-1:0] x);
    logic [BLK_W-1:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      r[i] = x[16*(i%4) + i/4];
    end
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] key_fwd(input logic [KEY_W-1:0] k,
                                               input logic [ROUND_W-1:0] rc);
    logic [KEY_W-1:0] t;
    t = {k[18:0], k[79:19]};
    t[79:76] = SBOX[t[79:76]];
    t[19:15] = t[19:15] ^ rc;
    return t;
  endfunction

  function automatic logic [KEY_W-1:0] key_inv(input logic [KEY_W-1:0] k,
                                               input logic [ROUND_W-1:0] rc);
    logic [KEY_W-1:0] t;
    t = k;
    t[19:15] = t[19:15] ^ rc;
    t[79:76] = SBOX_INV[t[79:76]];
    return {t[60:0], t[79:61]};
  endfunction

endpackage

`default_nettype wire

[design/present80_block_cipher_unit.sv]
// PRESENT-80 cipher unit: key registers, key expander, 31 round cells and
// the output stage. Depends on pres_pkg, pres_kexp and pres_round_cell.
//
// Usage:
//   Configuration: key_low (byte address 0) and key_high (byte address 8)
//   over the APB-style port; pready is always high. Write keys only while
//   no request is in flight.
//   Input channel: in_valid_i / in_stall_o carry command_i (0 encrypt,
//   1 decrypt) and block_in_i. Output channel: out_valid_o / out_stall_i
//   carry block_out_o, one result per request, in request order.
//   Path: the accept edge loads round cell 0; each round cell holds one
//   request, and the output stage adds the last key.
//   Throughput: one request per cycle while in_stall_o is low.
//   Reset and key writes: the key expander loads the key, then walks the
//   schedule for 31 steps; in_stall_o stays high meanwhile so decryption
//   starts from the last round key.
//   Receiver stall: the request at the output holds and stalls back
//   through the cells; empty cells keep filling, so the stall reaches
//   in_stall_o only when every stage is full.
`default_nettype none

module present80_block_cipher_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [63:0] block_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [63:0] block_out_o
);

  `include "assert_macros.svh"

  localparam int unsigned NR = pres_pkg::NUM_ROUNDS;

  logic [63:0]                   key_low_q;
  logic [15:0]                   key_high_q;
  logic                          cfg_wr;
  logic                          kx_busy;
  logic [pres_pkg::KEY_W-1:0]    key_cur;
  logic [pres_pkg::KEY_W-1:0]    key_last;

  logic                          valid_c [NR+1];
  logic                          stall_c [NR+1];
  pres_pkg::stage_t              data_c  [NR+1];

  logic                          out_valid_q;
  logic [63:0]                   block_out_q;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign key_cur = {key_high_q, key_low_q};

  always_comb begin
    unique case (paddr[3])
      pres_pkg::REG_KEY_LOW:  prdata = key_low_q;
      pres_pkg::REG_KEY_HIGH: prdata = {48'd0, key_high_q};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        pres_pkg::REG_KEY_LOW:  key_low_q  <= pwdata;
        pres_pkg::REG_KEY_HIGH: key_high_q <= pwdata[15:0];
        default:                key_low_q  <= key_low_q;
      endcase
    end
  end

  pres_kexp u_kexp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_wr_i   (cfg_wr),
    .key_i      (key_cur),
    .busy_o     (kx_busy),
    .last_key_o (key_last)
  );

  always_comb begin
    valid_c[0]    = in_valid_i & ~kx_busy;
    data_c[0].cmd = pres_pkg::cmd_e'(command_i);
    data_c[0].blk = block_in_i;
    data_c[0].key = (command_i == pres_pkg::CMD_DEC) ? key_last : key_cur;
  end

  assign in_stall_o = kx_busy | stall_c[0];

  for (genvar k = 0; k < NR; k++) begin : g_round
    pres_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .round_i (pres_pkg::ROUND_W'(k)),
      .valid_i (valid_c[k]),
      .data_i  (data_c[k]),
      .stall_o (stall_c[k]),
      .valid_o (valid_c[k+1]),
      .data_o  (data_c[k+1]),
      .stall_i (stall_c[k+1])
    );
  end

  assign stall_c[NR] = out_valid_q & out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!stall_c[NR]) begin
      out_valid_q <= valid_c[NR];
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_c[NR] && !stall_c[NR]) begin
      block_out_q <= data_c[NR].blk ^ data_c[NR].key[79:16];
    end
  end

  assign out_valid_o = out_valid_q;
  assign block_out_o = block_out_q;

  `PRES_ASSERT_IMP(a_top_busy_stall, kx_busy, in_stall_o,
                   "request taken while key expander busy")
  `PRES_ASSERT_IMP(a_top_out_hold, out_valid_q && out_stall_i,
                   ##1 (out_valid_q && $stable(block_out_q)),
                   "output stage dropped or changed a stalled result")

endmodule

`default_nettype wire

[design/pres_kexp.sv]
// Key expander: walks the schedule 31 steps after reset or a key write
// to find the last round key register. Depends on pres_pkg.
`default_nettype none

module pres_kexp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      key_wr_i,
  input  wire logic [pres_pkg::KEY_W-1:0] key_i,
  output logic                           busy_o,
  output logic [pres_pkg::KEY_W-1:0]     last_key_o
);

  `include "assert_macros.svh"

  pres_pkg::kx_state_e             state_q, state_d;
  logic [pres_pkg::ROUND_W-1:0]    cnt_q, cnt_d;
  logic [pres_pkg::KEY_W-1:0]      work_q, work_d;

  always_comb begin
    state_d = state_q;
    if (key_wr_i) begin
      state_d = pres_pkg::KX_LOAD;
    end else begin
      unique case (state_q)
        pres_pkg::KX_IDLE: state_d = pres_pkg::KX_IDLE;
        pres_pkg::KX_LOAD: state_d = pres_pkg::KX_RUN;
        pres_pkg::KX_RUN: begin
          if (cnt_q == pres_pkg::ROUND_W'(pres_pkg::NUM_ROUNDS)) begin
            state_d = pres_pkg::KX_IDLE;
          end
        end
        default: state_d = pres_pkg::KX_LOAD;
      endcase
    end
  end

  always_comb begin
    busy_o     = (state_q != pres_pkg::KX_IDLE);
    last_key_o = work_q;
  end

  always_comb begin
    cnt_d  = cnt_q;
    work_d = work_q;
    unique case (state_q)
      pres_pkg::KX_LOAD: begin
        work_d = key_i;
        cnt_d  = pres_pkg::ROUND_W'(1);
      end
      pres_pkg::KX_RUN: begin
        work_d = pres_pkg::key_fwd(work_q, cnt_q);
        cnt_d  = cnt_q + pres_pkg::ROUND_W'(1);
      end
      default: begin
        cnt_d  = cnt_q;
        work_d = work_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pres_pkg::KX_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  `PRES_ASSERT_IMP(a_kexp_full_walk, $fell(busy_o) && !$past(key_wr_i),
                   $past(cnt_q) == pres_pkg::ROUND_W'(pres_pkg::NUM_ROUNDS),
                   "key expander left run before the last step")

endmodule

`default_nettype wire

[design/pres_round_cell.sv]
// One cipher round with its key schedule step and a pipeline register.
// Encrypts or decrypts per request. Depends on pres_pkg.
`default_nettype none

module pres_round_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [pres_pkg::ROUND_W-1:0] round_i,
  input  wire logic                         valid_i,
  input  wire pres_pkg::stage_t             data_i,
  output logic                              stall_o,
  output logic                              valid_o,
  output pres_pkg::stage_t                  data_o,
  input  wire logic                         stall_i
);

  `include "assert_macros.svh"

  logic                         valid_q, valid_d;
  pres_pkg::stage_t             data_q, data_d;
  logic [pres_pkg::BLK_W-1:0]   mixed;
  logic [pres_pkg::ROUND_W-1:0] rc_enc, rc_dec;

  always_comb begin
    mixed  = data_i.blk ^ data_i.key[79:16];
    rc_enc = round_i + pres_pkg::ROUND_W'(1);
    rc_dec = pres_pkg::ROUND_W'(pres_pkg::NUM_ROUNDS) - round_i;
    data_d.cmd = data_i.cmd;
    unique case (data_i.cmd)
      pres_pkg::CMD_ENC: begin
        data_d.blk = pres_pkg::perm_layer(pres_pkg::sbox_layer(mixed));
        data_d.key = pres_pkg::key_fwd(data_i.key, rc_enc);
      end
      pres_pkg::CMD_DEC: begin
        data_d.blk = pres_pkg::sbox_inv_layer(pres_pkg::perm_inv_layer(mixed));
        data_d.key = pres_pkg::key_inv(data_i.key, rc_dec);
      end
      default: begin
        data_d.blk = mixed;
        data_d.key = data_i.key;
      end
    endcase
  end

  assign stall_o = valid_q & stall_i;
  assign valid_d = stall_o ? valid_q : valid_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  `PRES_ASSERT_IMP(a_cell_hold, valid_q && stall_i, ##1 (valid_q && $stable(data_q)),
                   "round cell lost or changed a held request")

endmodule

`default_nettype wire

[dv/present80_checker.sv]
// Scoreboard for present80_block_cipher_unit: snoops key writes on the APB-style
// port, predicts each accepted request and compares every accepted result in order.
// Depends on pres_pkg for cmd_e and the register select codes.
module present80_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        command_i,
  input  logic [63:0] block_in_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [63:0] block_out_o,
  output int          pending_o,
  output int          mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] FWD_SUB [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };
  localparam logic [3:0] INV_SUB [16] = '{
    4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
    4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
  };

  logic [63:0] key_lo;
  logic [15:0] key_hi;
  logic [63:0] expected_blocks [$];
  int          results_seen;

  function automatic logic [63:0] sub_nibbles(input logic [63:0] x, input bit inv);
    logic [63:0] r;
    r = '0;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = inv ? INV_SUB[x[4*n +: 4]] : FWD_SUB[x[4*n +: 4]];
    end
    return r;
  endfunction

  function automatic logic [63:0] scatter_bits(input logic [63:0] x);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      r[16*(i%4) + i/4] = x[i];
    end
    return r;
  endfunction

  function automatic logic [63:0] gather_bits(input logic [63:0] x);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      r[i] = x[16*(i%4) + i/4];
    end
    return r;
  endfunction

  function automatic logic [63:0] cipher_result(input pres_pkg::cmd_e cmd,
                                                input logic [63:0] blk,
                                                input logic [79:0] key);
    logic [63:0] rk [32];
    logic [79:0] k;
    logic [63:0] s;
    k = key;
    for (int r = 0; r < 32; r++) begin
      rk[r] = k[79:16];
      k = {k[18:0], k[79:19]};
      k[79:76] = FWD_SUB[k[79:76]];
      k[19:15] = k[19:15] ^ 5'(r + 1);
    end
    s = blk;
    if (cmd == pres_pkg::CMD_ENC) begin
      for (int r = 0; r < 31; r++) begin
        s = scatter_bits(sub_nibbles(s ^ rk[r], 1'b0));
      end
      s = s ^ rk[31];
    end else begin
      for (int r = 31; r > 0; r--) begin
        s = sub_nibbles(gather_bits(s ^ rk[r]), 1'b1);
      end
      s = s ^ rk[0];
    end
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] want;
    if (!rst_ni) begin
      key_lo       <= '0;
      key_hi       <= '0;
      expected_blocks.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
      results_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[3] == pres_pkg::REG_KEY_HIGH) begin
          key_hi <= pwdata[15:0];
        end else begin
          key_lo <= pwdata;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_blocks.push_back(cipher_result(pres_pkg::cmd_e'(command_i), block_in_i,
                                                {key_hi, key_lo}));
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (expected_blocks.size() == 0) begin
          if (mismatches_o < 10) begin
            $display("result %0d: block_out %h arrived with no request pending",
                     results_seen, block_out_o);
          end
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = expected_blocks.pop_front();
          if (block_out_o !== want) begin
            if (mismatches_o < 10) begin
              $display("result %0d: block_out expected %h got %h",
                       results_seen, want, block_out_o);
            end
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      pending_o <= expected_blocks.size();
    end
  end

endmodule

[dv/tb_present80_block_cipher_unit.sv]
// Top of the present80_block_cipher_unit testbench: clock, reset, key writes,
// request and result handshakes, verdict. Needs pres_pkg, the unit and present80_checker.
module tb_present80_block_cipher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [63:0] pwdata      = '0;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        command_i   = 1'b0;
  logic [63:0] block_in_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] block_out_o;
  int          pending;
  int          mismatches;

  int gap_max    = 0;
  int stall_max  = 0;
  int hold_off   = 0;
  int sent       = 0;
  int key_writes = 0;

  present80_block_cipher_unit u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata(), .pready,
    .in_valid_i, .in_stall_o, .command_i, .block_in_i,
    .out_valid_o, .out_stall_i, .block_out_o
  );

  present80_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_o, .command_i, .block_in_i,
    .out_valid_o, .out_stall_i, .block_out_o,
    .pending_o(pending), .mismatches_o(mismatches)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic write_key_reg(input logic reg_sel, input logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    key_writes++;
  endtask

  task automatic send_request(input pres_pkg::cmd_e cmd, input logic [63:0] blk);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    block_in_i <= blk;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || out_valid_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_key(input logic [63:0] lo, input logic [63:0] hi);
    drain();
    write_key_reg(pres_pkg::REG_KEY_LOW, lo);
    write_key_reg(pres_pkg::REG_KEY_HIGH, hi);
  endtask

  task automatic send_patterns;
    logic [63:0] pats [6];
    pats = '{64'h0, '1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
             64'h1, 64'h8000_0000_0000_0000};
    foreach (pats[i]) begin
      send_request(pres_pkg::CMD_ENC, pats[i]);
      send_request(pres_pkg::CMD_DEC, pats[i]);
    end
  endtask

  function automatic logic [63:0] random_block();
    case ($urandom_range(7, 0))
      0:       return 64'h1 << $urandom_range(63, 0);
      1:       return ~(64'h1 << $urandom_range(63, 0));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    fork
      forever begin
        int d;
        if (hold_off > 0) begin
          out_stall_i <= 1'b1;
          repeat (hold_off) @(posedge clk_i);
          hold_off = 0;
        end
        d = $urandom_range(stall_max, 0);
        if (d > 0) begin
          out_stall_i <= 1'b1;
          repeat (d) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
      end
    join_none

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_patterns();
    set_key('1, '1);
    send_patterns();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_key(64'h0123_4567_89AB_CDEF, 64'hFEDC);
        5:       set_key('0, 64'hFFFF);
        default: set_key({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      gap_max   = (ph % 2 == 1) ? 7 : 0;
      stall_max = (ph % 3 == 0) ? 0 : 7;
      if (ph == 2) begin
        gap_max  = 0;
        hold_off = 400;
      end
      repeat (275) begin
        send_request(pres_pkg::cmd_e'(1'($urandom_range(1, 0))), random_block());
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d encrypt/decrypt requests under %0d key register writes,",
             sent, key_writes);
    $display("with random sender gaps, receiver stalls and one long output hold-off.");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
